>>> hw/rtl/ntc_adc_to_celsius_assert.svh
// Assertion macros for the thermistor converter; each expects clock and reset in scope.
`ifndef NTC_ADC_TO_CELSIUS_ASSERT_SVH
`define NTC_ADC_TO_CELSIUS_ASSERT_SVH

// Same-cycle implication.
`define NTC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ntc_pkg.sv
// Shared types, constants and fixed-point helpers for the thermistor converter.
package ntc_pkg;

   // Field and register widths
   localparam int ADC_BITS   = 12;
   localparam int FRAC_BITS  = 24;
   localparam int SER_W      = 20;
   localparam int NOM_W      = 20;
   localparam int BETA_W     = 14;
   localparam int CK_W       = 16;
   localparam int TEMP_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int REQ_DATA_W = ((2 * ADC_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((TEMP_W + 7) / 8) * 8;

   // Register reset values
   localparam logic [SER_W-1:0]  SERIES_RST = SER_W'(10000);
   localparam logic [NOM_W-1:0]  NOMINAL_RST = NOM_W'(10000);
   localparam logic [BETA_W-1:0] BETA_RST = BETA_W'(3950);
   localparam logic [CK_W-1:0]   CENTIK_RST = CK_W'(29815);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERIES  = 2'd0,
      CSR_NOMINAL = 2'd1,
      CSR_BETA    = 2'd2,
      CSR_CENTIK  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      LG_IDLE,
      LG_NORM,
      LG_SQUARE
   } lg_state_type;

   // Resistance and log2 widths
   localparam int PROD_W = ADC_BITS + SER_W;
   localparam int DVS_W  = ADC_BITS + 1;
   localparam int TOP_W  = $clog2(PROD_W);
   localparam int MANT_W = 32;
   localparam int LOG_W  = TOP_W + FRAC_BITS;

   // Temperature datapath widths
   localparam int DIFF_W    = LOG_W + 1;
   localparam int LN_PROD_W = LOG_W + 32;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam int CL_W  = CK_W + 1 + DIFF_W;
   localparam int DEN_W = CL_W + 1;
   localparam int CB_W  = CK_W + BETA_W;
   localparam int N2_W  = CB_W + 7 + FRAC_BITS;
   localparam int QT_W  = 17;
   localparam int LIM_W = DEN_W + QT_W;
   localparam int QLIM  = 100000;
   localparam int TC_OFS = 27265;
   localparam int TX_W   = QT_W + 1;
   localparam int RECIP_W = 18;
   localparam int RECIP100 = 167773;
   localparam int RECIP_SH = 24;
   localparam int PR_W  = QT_W + RECIP_W;
   localparam int QUO_W = 10;
   localparam int TEMP_MAX = 255;
   localparam int TEMP_MIN = -128;

   // Effective configuration (zero registers other than series already forced to one)
   typedef struct packed {
      logic [SER_W-1:0]  series;
      logic [NOM_W-1:0]  nominal;
      logic [BETA_W-1:0] beta;
      logic [CK_W-1:0]   centik;
   } cfg_type;

   typedef struct packed {
      logic [TOP_W-1:0]  top;
      logic [MANT_W-1:0] mant;
   } norm_type;

   typedef struct packed {
      logic [MANT_W-1:0] mant;
      logic              hi;
   } sq_type;

   // Integer part of log2 and the Q1.31 mantissa
   function automatic norm_type log_norm(input logic [PROD_W-1:0] x);
      norm_type r;
      logic [TOP_W-1:0] top;
      logic [PROD_W+MANT_W-2:0] ext;
      top = '0;
      for (int i = 1; i < PROD_W; i++) begin
         if (x[i]) top = TOP_W'(i);
      end
      ext = {x, {(MANT_W-1){1'b0}}};
      r.top = top;
      r.mant = MANT_W'(ext >> top);
      return r;
   endfunction

   // One fraction bit: square the mantissa and renormalize
   function automatic sq_type sq_step(input logic [MANT_W-1:0] m);
      sq_type r;
      logic [2*MANT_W-1:0] sq;
      sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
      r.hi = sq[2*MANT_W-1];
      r.mant = r.hi ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
      return r;
   endfunction

endpackage

>>> hw/rtl/ntc_resist.sv
// Sample averaging and pipelined restoring divider for the thermistor resistance.
module ntc_resist (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [ntc_pkg::ADC_BITS-1:0] sample_a,
   input  logic [ntc_pkg::ADC_BITS-1:0] sample_b,
   input  logic [ntc_pkg::SER_W-1:0]    series,
   output logic                         out_valid,
   output logic [ntc_pkg::PROD_W-1:0]   res
);
   import ntc_pkg::*;

   logic [ADC_BITS:0]   sum;
   logic [ADC_BITS-1:0] code;
   logic                f_valid_ff;
   logic [PROD_W-1:0]   f_prod_ff;
   logic [DVS_W-1:0]    f_dvs_ff;

   logic              v_ff   [PROD_W];
   logic [PROD_W-1:0] acc_ff [PROD_W];
   logic [DVS_W-1:0]  rem_ff [PROD_W];
   logic [DVS_W-1:0]  dvs_ff [PROD_W];

   // Floor average, then numerator and divisor
   assign sum  = {1'b0, sample_a} + {1'b0, sample_b};
   assign code = sum[ADC_BITS:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= in_valid;
      end
      if (en) begin
         f_prod_ff <= PROD_W'(code) * PROD_W'(series);
         f_dvs_ff  <= DVS_W'(1 << ADC_BITS) - DVS_W'(code);
      end
   end

   // One quotient bit per stage, MSB first
   for (genvar i = 0; i < PROD_W; i++) begin : g_div
      logic              vi;
      logic [PROD_W-1:0] acc_i;
      logic [DVS_W-1:0]  rem_i;
      logic [DVS_W-1:0]  dvs_i;
      logic [DVS_W:0]    trial;
      logic              ge;

      if (i == 0) begin : g_first
         assign vi    = f_valid_ff;
         assign acc_i = f_prod_ff;
         assign rem_i = '0;
         assign dvs_i = f_dvs_ff;
      end else begin : g_next
         assign vi    = v_ff[i-1];
         assign acc_i = acc_ff[i-1];
         assign rem_i = rem_ff[i-1];
         assign dvs_i = dvs_ff[i-1];
      end

      assign trial = {rem_i, acc_i[PROD_W-1]};
      assign ge    = trial >= {1'b0, dvs_i};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vi;
         end
         if (en) begin
            rem_ff[i] <= ge ? DVS_W'(trial - {1'b0, dvs_i}) : trial[DVS_W-1:0];
            acc_ff[i] <= {acc_i[PROD_W-2:0], ge};
            dvs_ff[i] <= dvs_i;
         end
      end
   end

   assign out_valid = v_ff[PROD_W-1];
   assign res       = acc_ff[PROD_W-1];

endmodule

>>> hw/rtl/ntc_log2.sv
// Pipelined fixed-point log2: normalize, then one squaring stage per fraction bit.
module ntc_log2 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [ntc_pkg::PROD_W-1:0] x,
   output logic                       out_valid,
   output logic                       out_zero,
   output logic [ntc_pkg::LOG_W-1:0]  log_x
);
   import ntc_pkg::*;

   norm_type          nrm;
   logic              n_valid_ff;
   logic              n_zero_ff;
   logic [MANT_W-1:0] n_mant_ff;
   logic [LOG_W-1:0]  n_lg_ff;

   logic              v_ff  [FRAC_BITS];
   logic              z_ff  [FRAC_BITS];
   logic [MANT_W-1:0] m_ff  [FRAC_BITS];
   logic [LOG_W-1:0]  lg_ff [FRAC_BITS];

   // Normalize stage
   assign nrm = log_norm(x);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (en) begin
         n_valid_ff <= in_valid;
      end
      if (en) begin
         n_zero_ff <= (x == '0);
         n_mant_ff <= nrm.mant;
         n_lg_ff   <= {nrm.top, {FRAC_BITS{1'b0}}};
      end
   end

   // Squaring stages
   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
      logic              vi;
      logic              zi;
      logic [MANT_W-1:0] mi;
      logic [LOG_W-1:0]  lgi;
      sq_type            s;

      if (i == 0) begin : g_first
         assign vi  = n_valid_ff;
         assign zi  = n_zero_ff;
         assign mi  = n_mant_ff;
         assign lgi = n_lg_ff;
      end else begin : g_next
         assign vi  = v_ff[i-1];
         assign zi  = z_ff[i-1];
         assign mi  = m_ff[i-1];
         assign lgi = lg_ff[i-1];
      end

      assign s = sq_step(mi);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vi;
         end
         if (en) begin
            z_ff[i]  <= zi;
            m_ff[i]  <= s.mant;
            lg_ff[i] <= {lgi[LOG_W-1:FRAC_BITS], lgi[FRAC_BITS-2:0], s.hi};
         end
      end
   end

   assign out_valid = v_ff[FRAC_BITS-1];
   assign out_zero  = z_ff[FRAC_BITS-1];
   assign log_x     = lg_ff[FRAC_BITS-1];

endmodule

>>> hw/rtl/ntc_log_seq.sv
// Iterative log2 of the nominal resistance, one fraction bit per cycle.
module ntc_log_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ntc_pkg::NOM_W-1:0] r0,
   output logic                      busy,
   output logic [ntc_pkg::LOG_W-1:0] log_r0
);
   import ntc_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS);

   lg_state_type      state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MANT_W-1:0] m_ff, m_in;
   logic [LOG_W-1:0]  lg_ff, lg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_NORM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      m_ff  <= m_in;
      lg_ff <= lg_in;
   end

   // Next state and datapath
   always_comb begin
      norm_type n;
      sq_type   s;
      n        = log_norm(PROD_W'(r0));
      s        = sq_step(m_ff);
      state_in = state_ff;
      cnt_in   = cnt_ff;
      m_in     = m_ff;
      lg_in    = lg_ff;
      case (state_ff)
         LG_IDLE: begin
         end
         LG_NORM: begin
            m_in     = n.mant;
            lg_in    = {n.top, {FRAC_BITS{1'b0}}};
            cnt_in   = '0;
            state_in = LG_SQUARE;
         end
         LG_SQUARE: begin
            m_in   = s.mant;
            lg_in  = {lg_ff[LOG_W-1:FRAC_BITS], lg_ff[FRAC_BITS-2:0], s.hi};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) state_in = LG_IDLE;
         end
         default: begin
            state_in = LG_NORM;
         end
      endcase
      // new R0 restarts the pass
      if (start) state_in = LG_NORM;
   end

   assign busy   = (state_ff != LG_IDLE);
   assign log_r0 = lg_ff;

endmodule

>>> hw/rtl/ntc_temp.sv
// Beta equation back end: ln ratio, denominator, long division, Celsius and clamp.
module ntc_temp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic                        in_zero,
   input  logic [ntc_pkg::LOG_W-1:0]   log_x,
   input  logic [ntc_pkg::LOG_W-1:0]   log_r0,
   input  ntc_pkg::cfg_type            cfg,
   output logic                        out_valid,
   output logic [ntc_pkg::TEMP_W-1:0]  temp,
   output ntc_pkg::status_type         status
);
   import ntc_pkg::*;

   // stage 1: log difference
   logic                     v1_ff, z1_ff;
   logic signed [DIFF_W-1:0] d1_ff;
   // stage 2: magnitude
   logic                     v2_ff, z2_ff, neg2_ff;
   logic [LOG_W-1:0]         mag2_ff;
   // stage 3: times ln 2
   logic                     v3_ff, z3_ff, neg3_ff;
   logic [LN_PROD_W-1:0]     lnp;
   logic [LOG_W-1:0]         lnm3_ff;
   // stage 4: signed ln, c*B
   logic                     v4_ff, z4_ff;
   logic signed [DIFF_W-1:0] lnv4_ff;
   logic [CB_W-1:0]          cb4_ff;
   // stage 5: c*L, scaled numerator
   logic                     v5_ff, z5_ff;
   logic signed [CL_W-1:0]   cl5_ff;
   logic [N2_W-1:0]          n25_ff;
   // stage 6: denominator
   logic                     v6_ff, z6_ff;
   logic signed [DEN_W-1:0]  base_s;
   logic signed [DEN_W-1:0]  den6_ff;
   logic [N2_W-1:0]          n26_ff;
   // stage 7: range limit
   logic                     v7_ff, z7_ff, s7_ff;
   logic [LIM_W-1:0]         lim7_ff;
   logic [DEN_W-2:0]         den7_ff;
   logic [N2_W-1:0]          n27_ff;
   // stage 8: overflow check
   logic                     v8_ff, z8_ff, s8_ff;
   logic [DEN_W-2:0]         den8_ff;
   logic [LIM_W-1:0]         rem8_ff;
   // division stages
   logic                     dv_ff   [QT_W];
   logic                     dz_ff   [QT_W];
   logic                     ds_ff   [QT_W];
   logic [DEN_W-2:0]         dden_ff [QT_W];
   logic [LIM_W-1:0]         drem_ff [QT_W];
   logic [QT_W-1:0]          dq_ff   [QT_W];
   // Celsius stages
   logic signed [TX_W-1:0]   tx;
   logic                     vc1_ff, zc1_ff, sc1_ff, negc1_ff;
   logic [QT_W-1:0]          ac1_ff;
   logic                     vc2_ff, zc2_ff, sc2_ff, negc2_ff;
   logic [PR_W-1:0]          pr;
   logic [QUO_W-1:0]         quoc2_ff;
   logic signed [QUO_W:0]    tsig;
   logic [TEMP_W-1:0]        temp_in, temp_ff;
   status_type               status_in, status_ff;
   logic                     vo_ff;

   assign lnp    = LN_PROD_W'(mag2_ff) * LN_PROD_W'(LN2_Q32);
   assign base_s = $signed((DEN_W'(cfg.beta) * DEN_W'(100)) << FRAC_BITS);

   // Valid chain for the fixed stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   // Payload of stages 1 to 8
   always_ff @(posedge clock) begin
      if (en) begin
         z1_ff   <= in_zero;
         d1_ff   <= $signed({1'b0, log_x}) - $signed({1'b0, log_r0});

         z2_ff   <= z1_ff;
         neg2_ff <= d1_ff[DIFF_W-1];
         mag2_ff <= d1_ff[DIFF_W-1] ? LOG_W'(-d1_ff) : LOG_W'(d1_ff);

         z3_ff   <= z2_ff;
         neg3_ff <= neg2_ff;
         lnm3_ff <= lnp[LN_PROD_W-1:32];

         z4_ff   <= z3_ff;
         lnv4_ff <= neg3_ff ? -$signed({1'b0, lnm3_ff}) : $signed({1'b0, lnm3_ff});
         cb4_ff  <= CB_W'(cfg.centik) * CB_W'(cfg.beta);

         z5_ff   <= z4_ff;
         cl5_ff  <= $signed({1'b0, cfg.centik}) * lnv4_ff;
         n25_ff  <= (N2_W'(cb4_ff) * N2_W'(100)) << FRAC_BITS;

         z6_ff   <= z5_ff;
         den6_ff <= base_s + DEN_W'(cl5_ff);
         n26_ff  <= n25_ff;

         z7_ff   <= z6_ff;
         s7_ff   <= den6_ff[DEN_W-1] || (den6_ff == '0);
         den7_ff <= den6_ff[DEN_W-2:0];
         lim7_ff <= LIM_W'(den6_ff[DEN_W-2:0]) * LIM_W'(QLIM);
         n27_ff  <= n26_ff;

         // 1000 kelvin or more saturates
         z8_ff   <= z7_ff;
         s8_ff   <= s7_ff || (LIM_W'(n27_ff) >= lim7_ff);
         den8_ff <= den7_ff;
         rem8_ff <= LIM_W'(n27_ff);
      end
   end

   // Centikelvin quotient, one bit per stage
   for (genvar i = 0; i < QT_W; i++) begin : g_qdiv
      localparam int K = QT_W - 1 - i;
      logic             vi, zi, si;
      logic [DEN_W-2:0] deni;
      logic [LIM_W-1:0] remi;
      logic [QT_W-1:0]  qi;
      logic [LIM_W-1:0] sub;
      logic             ge;

      if (i == 0) begin : g_first
         assign vi   = v8_ff;
         assign zi   = z8_ff;
         assign si   = s8_ff;
         assign deni = den8_ff;
         assign remi = rem8_ff;
         assign qi   = '0;
      end else begin : g_next
         assign vi   = dv_ff[i-1];
         assign zi   = dz_ff[i-1];
         assign si   = ds_ff[i-1];
         assign deni = dden_ff[i-1];
         assign remi = drem_ff[i-1];
         assign qi   = dq_ff[i-1];
      end

      assign sub = LIM_W'(deni) << K;
      assign ge  = remi >= sub;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i] <= 1'b0;
         end else if (en) begin
            dv_ff[i] <= vi;
         end
         if (en) begin
            dz_ff[i]   <= zi;
            ds_ff[i]   <= si;
            dden_ff[i] <= deni;
            drem_ff[i] <= ge ? remi - sub : remi;
            dq_ff[i]   <= {qi[QT_W-2:0], ge};
         end
      end
   end

   // Offset to Celsius hundredths, truncating divide by 100
   assign tx = $signed({1'b0, dq_ff[QT_W-1]}) - TX_W'(TC_OFS);
   assign pr = PR_W'(ac1_ff) * PR_W'(RECIP100);
   assign tsig = negc2_ff ? -$signed({1'b0, quoc2_ff}) : $signed({1'b0, quoc2_ff});

   // Clamp and status
   always_comb begin
      temp_in   = tsig[TEMP_W-1:0];
      status_in = ST_OK;
      if (zc2_ff) begin
         temp_in   = '0;
         status_in = ST_ZERO;
      end else if (sc2_ff || tsig > TEMP_MAX) begin
         temp_in   = TEMP_W'(TEMP_MAX);
         status_in = ST_SAT;
      end else if (tsig < TEMP_MIN) begin
         temp_in   = TEMP_W'(TEMP_MIN);
         status_in = ST_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc1_ff <= 1'b0;
         vc2_ff <= 1'b0;
         vo_ff  <= 1'b0;
      end else if (en) begin
         vc1_ff <= dv_ff[QT_W-1];
         vc2_ff <= vc1_ff;
         vo_ff  <= vc2_ff;
      end
      if (en) begin
         zc1_ff    <= dz_ff[QT_W-1];
         sc1_ff    <= ds_ff[QT_W-1];
         negc1_ff  <= tx[TX_W-1];
         ac1_ff    <= tx[TX_W-1] ? QT_W'(-tx) : QT_W'(tx);

         zc2_ff    <= zc1_ff;
         sc2_ff    <= sc1_ff;
         negc2_ff  <= negc1_ff;
         quoc2_ff  <= QUO_W'(pr >> RECIP_SH);

         temp_ff   <= temp_in;
         status_ff <= status_in;
      end
   end

   assign out_valid = vo_ff;
   assign temp      = temp_ff;
   assign status    = status_ff;

endmodule

>>> hw/rtl/ntc_adc_to_celsius.sv
// Top level of the NTC thermistor ADC-to-Celsius converter.
// Converts a pair of 12-bit divider readings to a rounded Celsius temperature with the
// Beta equation, fully pipelined: one word is accepted per clock while req_tready is
// high, and each word passes through the average and resistance divider, the log2 squaring
// chain, then the ln, denominator, 17-step centikelvin division and clamp. The whole
// pipeline holds while a result waits on rsp_tready. log2 of nominal_ohms comes from a
// shared iterative unit that runs after reset and after each write to nominal_ohms;
// req_tready stays low during that pass and while csr_valid is high. Status 1 flags
// zero resistance, status 2 a saturated temperature.
`include "ntc_adc_to_celsius_assert.svh"

module ntc_adc_to_celsius (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ntc_pkg::REQ_DATA_W-1:0]   req_tdata,   // sample_first, sample_second
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ntc_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // temp_celsius, zero fill
   output logic [1:0]                       rsp_tuser,   // status
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  ntc_pkg::csr_index_type           csr_index,
   input  logic [ntc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ntc_pkg::*;

   logic [SER_W-1:0]  series_ff;
   logic [NOM_W-1:0]  nominal_ff;
   logic [BETA_W-1:0] beta_ff;
   logic [CK_W-1:0]   centik_ff;
   cfg_type           cfg;

   logic              csr_wr;
   logic              lg_start;
   logic              lg_busy;
   logic [LOG_W-1:0]  log_r0;
   logic              en;
   logic              accept;

   logic              rs_valid;
   logic [PROD_W-1:0] rs_res;
   logic              lg_valid;
   logic              lg_zero;
   logic [LOG_W-1:0]  lg_val;
   logic [TEMP_W-1:0] temp;
   status_type        status;

   // Configuration registers
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign lg_start  = csr_wr && (csr_index == CSR_NOMINAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= SERIES_RST;
         nominal_ff <= NOMINAL_RST;
         beta_ff    <= BETA_RST;
         centik_ff  <= CENTIK_RST;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_SERIES:  series_ff  <= csr_wdata[SER_W-1:0];
            CSR_NOMINAL: nominal_ff <= csr_wdata[NOM_W-1:0];
            CSR_BETA:    beta_ff    <= csr_wdata[BETA_W-1:0];
            CSR_CENTIK:  centik_ff  <= csr_wdata[CK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Zero registers act as one, except series
   assign cfg.series  = series_ff;
   assign cfg.nominal = (nominal_ff == '0) ? NOM_W'(1) : nominal_ff;
   assign cfg.beta    = (beta_ff == '0) ? BETA_W'(1) : beta_ff;
   assign cfg.centik  = (centik_ff == '0) ? CK_W'(1) : centik_ff;

   // Global advance: the last stage doubles as the output register
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !lg_busy && !csr_valid;
   assign accept     = req_tvalid && req_tready;

   ntc_log_seq u_log_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (lg_start),
      .r0     (cfg.nominal),
      .busy   (lg_busy),
      .log_r0 (log_r0)
   );

   ntc_resist u_resist (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .sample_a  (req_tdata[ADC_BITS-1:0]),
      .sample_b  (req_tdata[2*ADC_BITS-1:ADC_BITS]),
      .series    (cfg.series),
      .out_valid (rs_valid),
      .res       (rs_res)
   );

   ntc_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rs_valid),
      .x         (rs_res),
      .out_valid (lg_valid),
      .out_zero  (lg_zero),
      .log_x     (lg_val)
   );

   ntc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (lg_valid),
      .in_zero   (lg_zero),
      .log_x     (lg_val),
      .log_r0    (log_r0),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .temp      (temp),
      .status    (status)
   );

   assign rsp_tdata = {{(RSP_DATA_W-TEMP_W){1'b0}}, temp};
   assign rsp_tuser = status;

   // Checks
   `NTC_ASSERT_NOW(a_zero_temp, rsp_tvalid && (rsp_tuser == ST_ZERO), rsp_tdata[TEMP_W-1:0] == '0, "zero fault with nonzero temperature")
   `NTC_ASSERT_NOW(a_sat_rail, rsp_tvalid && (rsp_tuser == ST_SAT), (rsp_tdata[TEMP_W-1:0] == TEMP_W'(TEMP_MAX)) || (rsp_tdata[TEMP_W-1:0] == TEMP_W'(TEMP_MIN)), "saturated word off the rails")
   `NTC_ASSERT_NEXT(a_r0_block, lg_start, !req_tready, "input open during log2 of nominal_ohms")

endmodule

>>> verif/ntc_adc_to_celsius_tb.sv
// Self-checking testbench for the thermistor ADC-to-Celsius converter.
`timescale 1ns / 1ps

module testbench;
   import ntc_pkg::*;

   int errors = 0;

   task automatic report_error(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Scoreboard: predicts the temperature for each accepted word and checks results
   class temp_scoreboard;
      logic [19:0] series_ohms, nominal_ohms;
      logic [13:0] beta_k;
      logic [15:0] nominal_ck;
      logic [8:0]  exp_temp[$];
      status_type  exp_status[$];
      int          checked;

      function void restore();
         series_ohms = 10000; nominal_ohms = 10000; beta_k = 3950; nominal_ck = 29815;
      endfunction

      function void write_reg(csr_index_type idx, logic [19:0] val);
         case (idx)
            CSR_SERIES:  series_ohms = val;
            CSR_NOMINAL: nominal_ohms = val;
            CSR_BETA:    beta_k = val[13:0];
            CSR_CENTIK:  nominal_ck = val[15:0];
            default:     ;
         endcase
      endfunction

      // log2 of x in unsigned Q.24 by repeated squaring of a Q1.31 mantissa
      function longint unsigned log2_q24(longint unsigned x);
         int top;
         longint unsigned m, sq, frac;
         top = 0;
         frac = 0;
         while (top < 63 && (x >> (top + 1)) != 0) top++;
         m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
         for (int i = 0; i < 24; i++) begin
            sq = m * m;
            if (sq[63]) begin
               frac = (frac << 1) | 1;
               m = sq >> 32;
            end else begin
               frac = frac << 1;
               m = sq >> 31;
            end
         end
         return (64'(top) << 24) | frac;
      endfunction

      function void note_sample(logic [11:0] first, logic [11:0] second);
         longint unsigned code, res, r0, b, c, mag, lnmag, num, q, rem, tcenti;
         longint d, lnv, den, t;
         status_type st;
         code = (64'(first) + 64'(second)) >> 1;
         res = (code * series_ohms) / (4096 - code);
         r0 = nominal_ohms == 0 ? 1 : nominal_ohms;
         b = beta_k == 0 ? 1 : beta_k;
         c = nominal_ck == 0 ? 1 : nominal_ck;
         st = ST_OK;
         if (res == 0) begin
            exp_temp.push_back(9'd0);
            exp_status.push_back(ST_ZERO);
            return;
         end
         d = longint'(log2_q24(res)) - longint'(log2_q24(r0));
         mag = d < 0 ? -d : d;
         lnmag = (mag >> 32) * 64'd2977044472 + (((mag & 64'hFFFFFFFF) * 64'd2977044472) >> 32);
         lnv = d < 0 ? -longint'(lnmag) : longint'(lnmag);
         den = longint'((100 * b) << 24) + longint'(c) * lnv;
         if (den <= 0) begin
            t = 255; st = ST_SAT;
         end else begin
            num = (c * b) << 24;
            q = num / den;
            rem = num % den;
            if (q >= 1000) begin
               t = 255; st = ST_SAT;
            end else begin
               tcenti = 100 * q + (100 * rem) / den;
               t = (longint'(tcenti) - 27265) / 100;
               if (t > 255) begin
                  t = 255; st = ST_SAT;
               end else if (t < -128) begin
                  t = -128; st = ST_SAT;
               end
            end
         end
         exp_temp.push_back(t[8:0]);
         exp_status.push_back(st);
      endfunction

      task check_result(logic [8:0] temp, logic [1:0] st);
         checked++;
         if (exp_temp.size() == 0) begin
            report_error($sformatf("unexpected word temp=%0d", $signed(temp)));
            return;
         end
         if (temp !== exp_temp[0])
            report_error($sformatf("temp %0d, expected %0d", $signed(temp),
                                   $signed(exp_temp[0])));
         if (st !== exp_status[0])
            report_error($sformatf("status %0d, expected %0d", st, exp_status[0]));
         void'(exp_temp.pop_front());
         void'(exp_status.pop_front());
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // sample_first, sample_second
   logic rsp_tvalid, rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // temp_celsius, zero fill
   logic [1:0] rsp_tuser;                   // status
   logic csr_valid = 0, csr_ready;
   csr_index_type csr_index = CSR_SERIES;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   temp_scoreboard board = new();
   int sent = 0;
   int idle_cycles = 0;
   bit hold_rsp = 0;
   bit rsp_stall_on = 1;

   ntc_adc_to_celsius dut (.*);

   initial forever #1 clock = ~clock;

   // Valid stays high after a handshake so a zero gap gives back-to-back words
   task automatic send_sample(logic [11:0] first, logic [11:0] second, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 8) : 0;
      if (gaps && $urandom_range(0, 3) == 0) gap = 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {first, second} == 0 ? '0 : REQ_DATA_W'({second, first});
      do @(posedge clock); while (!req_tready);
      board.note_sample(first, second);
      sent++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [19:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Stop offering and wait for the pipeline to drain before touching registers
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (board.exp_temp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic random_samples(int n);
      logic [11:0] a;
      for (int i = 0; i < n; i++) begin
         a = 12'($urandom_range(0, 4095));
         case ($urandom_range(0, 3))
            0: send_sample(a, a, 1);
            1: send_sample(a, 12'(a + $urandom_range(0, 40)), 1);
            default: send_sample(12'($urandom), 12'($urandom), 1);
         endcase
      end
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_tready <= 0;
         else begin
            gap = rsp_stall_on ? $urandom_range(0, 8) : 0;
            if (gap != 0 && $urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
               rsp_tready <= 0;
               repeat (gap - 1) @(negedge clock);
               @(negedge clock);
            end
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata[8:0], rsp_tuser);
   end

   // Watchdog: cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || hold_rsp)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("watchdog expired");
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      board.restore();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes and special cases at reset settings
      send_sample(0, 0, 0);          // zero resistance
      send_sample(12'hFFF, 12'hFFF, 0);
      send_sample(0, 1, 0);          // floor average to zero
      send_sample(1, 2, 0);
      send_sample(12'h800, 12'h800, 0);
      send_sample(12'hAAA, 12'h555, 0);
      send_sample(12'h555, 12'hAAA, 0);
      send_sample(12'h010, 12'h010, 0); // very hot
      send_sample(12'hFF0, 12'hFFF, 0); // very cold
      drain();

      // Extreme settings: zero series gives the fault, zero registers act as one
      write_reg(CSR_SERIES, 0);
      send_sample(12'h800, 12'h801, 0);
      drain();
      write_reg(CSR_SERIES, 20'hFFFFF);
      write_reg(CSR_NOMINAL, 0);
      write_reg(CSR_BETA, 0);
      write_reg(CSR_CENTIK, 0);
      send_sample(12'hFFF, 12'hFFF, 0);
      send_sample(12'h001, 12'h002, 0);
      drain();
      write_reg(CSR_SERIES, 1);
      write_reg(CSR_NOMINAL, 1000000);
      write_reg(CSR_BETA, 10000);
      write_reg(CSR_CENTIK, 40000);
      send_sample(12'hFFF, 12'hFFE, 0);
      send_sample(12'h400, 12'h400, 0);
      drain();
      write_reg(CSR_SERIES, 1000000);
      write_reg(CSR_NOMINAL, 1);
      write_reg(CSR_BETA, 1000);
      write_reg(CSR_CENTIK, 20000);     // cold region, results saturate low
      send_sample(12'hFFF, 12'hFFF, 0);
      send_sample(12'h800, 12'h800, 0);
      send_sample(12'h002, 12'h002, 0);
      drain();

      // Random phases, each under its own setting
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 0) begin
            write_reg(CSR_SERIES, 10000); write_reg(CSR_NOMINAL, 10000);
            write_reg(CSR_BETA, 3950); write_reg(CSR_CENTIK, 29815);
         end else begin
            write_reg(CSR_SERIES, 20'($urandom));
            write_reg(CSR_NOMINAL, 20'($urandom));
            write_reg(CSR_BETA, 20'($urandom));
            write_reg(CSR_CENTIK, 20'($urandom));
         end
         if (ph == 2) begin
            // Long receiver hold-off while the sender keeps offering words
            fork
               begin
                  hold_rsp = 1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 0;
               end
               random_samples(110);
            join
         end else if (ph == 4) begin
            rsp_stall_on = 0;
            random_samples(110);
            rsp_stall_on = 1;
         end else random_samples(110);
         drain();   // sender pauses until every result is back
      end

      $display("covered %0d words, %0d results, register sweeps at extremes and random",
               sent, board.checked);
      $display("stalls on both sides, one long receiver hold-off");
      if (errors == 0 && board.exp_temp.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_resist.sv
hw/rtl/ntc_log2.sv
hw/rtl/ntc_log_seq.sv
hw/rtl/ntc_temp.sv
hw/rtl/ntc_adc_to_celsius.sv
verif/ntc_adc_to_celsius_tb.sv
